>>> hdl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes of the list engine: item structs, opcodes, status
// codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6,
    OP_DUMP       = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // walk index update
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_CNT  = 3'd2,
    IDX_POS1 = 3'd3,
    IDX_INC  = 3'd4,
    IDX_DEC  = 3'd5
  } idx_op_t;

  typedef struct packed {
    op_t                       op;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] value;
  } sle_in_t;

  typedef struct packed {
    status_t                   status;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] data;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } sle_out_t;

  typedef struct packed {
    logic    take;       // latch the input item
    logic    rd;         // RAM read
    logic    wr;         // RAM write
    logic    prev;       // address idx-1 instead of idx
    logic    put;        // write value at effective position
    logic    cnt_inc;
    logic    cnt_dec;
    idx_op_t idx_op;
    logic    out_load;
    status_t out_status;
    logic    use_idx;
    logic    use_data;
    logic    last;
  } sle_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic idx_gt_pos;
    logic idx_lt_cnt;
    logic match;
    logic dump_last;
    logic out_free;
  } sle_sts_t;

endpackage

>>> hdl/sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Bounded ordered list of signed words with push/pop at both ends, insert
// and erase at a position, find and dump.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  (valid/ready): one command item {op, pos, value}.
//   out_item (valid/ready): result items {status, index, data, count, last}.
//   Every command gives one result item, except a dump of a non-empty list,
//   which gives one item per element with last set on the final one.
// Sequencing from acceptance to result loaded:
//   pop back, full/empty/bad-position rejects: straight to the result
//   insert/push:  shifts entries from the position up by one, top first
//   erase/pop front: shifts the entries above the position down by one
//   find: compares entries from index 0 until a match or the count
//   dump: reads each element, then loads it as a result item
//   The walk goes through the element RAM one entry at a time (read,
//   then write or compare), so long commands walk up to DEPTH entries.
// One command is worked at a time; in_ready is high only when the
// sequencer is idle. Results sit in an output register, so the next command
// is taken while the last result still waits. A stalled receiver holds the
// sequencer on its next result; nothing is dropped.
// Reset (rst_n low, synchronous) empties the list; element RAM contents are
// not cleared and entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sle_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output sle_out_t out_item
);

  sle_cmd_t cmd;
  sle_sts_t sts;

  // sequencer
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, counters and output register
  sle_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> hdl/sle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sle_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_dpath
// List datapath: element RAM, fill count, walk index, command latch and
// output register.
// ----------------------------------------------------------------------------
module sle_dpath import sle_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sle_in_t  in_item,
  input  sle_cmd_t cmd,
  output sle_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output sle_out_t out_item
);

  localparam int IW = $clog2(DEPTH);
  localparam int XW = IW + 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (XW > POS_W) ? XW : POS_W;

  op_t                  op_r;
  logic [POS_W-1:0]     pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [XW-1:0]        idx_r, idx_nxt;
  logic [XW-1:0]        idx_m1;
  logic [PW-1:0]        epos;
  logic [PW-1:0]        cnt_w, idx_w;
  logic                 out_valid_r, out_valid_nxt;
  sle_out_t             out_r, out_nxt;

  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [95:0]           val_ext;
  logic signed [63:0]    data_ext;
  logic [63:0]           idx_ext, cnt_ext;

  // value: low DATA_WIDTH bits, zero above 32
  assign val_ext = 96'($unsigned(in_item.value));
  assign val_nxt = val_ext[DATA_WIDTH-1:0];

  assign cnt_w  = PW'(cnt_r);
  assign idx_w  = PW'(idx_r);
  assign idx_m1 = idx_r - XW'(1);

  always_comb begin
    unique case (op_r)
      OP_PUSH_BACK:              epos = cnt_w;
      OP_PUSH_FRONT, OP_POP_FRONT: epos = '0;
      default:                   epos = PW'(pos_r);
    endcase
  end

  // RAM ports
  assign ram_re    = cmd.rd;
  assign ram_raddr = cmd.prev ? idx_m1[IW-1:0] : idx_r[IW-1:0];
  assign ram_we    = cmd.wr;
  assign ram_waddr = cmd.put ? epos[IW-1:0]
                   : (cmd.prev ? idx_m1[IW-1:0] : idx_r[IW-1:0]);
  assign ram_wdata = cmd.put ? val_r : ram_rdata;

  sle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status toward the controller
  always_comb begin
    sts.op         = op_r;
    sts.empty      = (cnt_r == '0);
    sts.full       = (cnt_r == CW'(DEPTH));
    sts.pos_gt_cnt = (epos > cnt_w);
    sts.pos_ge_cnt = (epos >= cnt_w);
    sts.idx_gt_pos = (idx_w > epos);
    sts.idx_lt_cnt = (idx_w < cnt_w);
    sts.match      = (ram_rdata == val_r);
    sts.dump_last  = ((idx_w + PW'(1)) == cnt_w);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_ZERO: idx_nxt = '0;
      IDX_CNT:  idx_nxt = XW'(cnt_r);
      IDX_POS1: idx_nxt = XW'(epos + PW'(1));
      IDX_INC:  idx_nxt = idx_r + XW'(1);
      IDX_DEC:  idx_nxt = idx_m1;
      default:  idx_nxt = idx_r;
    endcase
  end

  // result formatting: dump data sign-extended from DATA_WIDTH
  assign data_ext = 64'($signed(ram_rdata));
  assign idx_ext  = 64'(idx_r);
  assign cnt_ext  = 64'(cnt_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = cmd.out_status;
      out_nxt.index  = cmd.use_idx ? idx_ext[INDEX_W-1:0] : '0;
      out_nxt.data   = cmd.use_data ? data_ext[VALUE_W-1:0] : '0;
      out_nxt.count  = cnt_ext[COUNT_W-1:0];
      out_nxt.last   = cmd.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= in_item.op;
      pos_r <= in_item.pos;
      val_r <= val_nxt;
    end
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (cnt_r != CW'(DEPTH)))
    else $error("count increment while full");

  a_no_shrink_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (cnt_r != '0))
    else $error("count decrement while empty");

endmodule

>>> hdl/sle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl
// Command sequencer: decodes the latched item, walks the store and hands
// results to the output register.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sle_sts_t sts,
  output sle_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_ERS_RD,
    S_ERS_WR,
    S_FND_RD,
    S_FND_CMP,
    S_DMP_RD,
    S_DMP_OUT,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t resp_r, resp_nxt;
  logic    use_idx_r, use_idx_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    resp_nxt    = resp_r;
    use_idx_nxt = use_idx_r;
    cmd         = '0;
    cmd.idx_op  = IDX_HOLD;
    cmd.out_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        use_idx_nxt = 1'b0;
        resp_nxt    = ST_OK;
        unique case (sts.op)
          OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
            if (sts.pos_gt_cnt) begin
              resp_nxt  = ST_BADPOS;
              state_nxt = S_RESP;
            end else if (sts.full) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.idx_op = IDX_CNT;
              state_nxt  = S_INS_RD;
            end
          end
          OP_POP_BACK: begin
            if (sts.empty) begin
              resp_nxt = ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
            state_nxt = S_RESP;
          end
          OP_POP_FRONT, OP_ERASE: begin
            if (sts.empty) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else if (sts.pos_ge_cnt) begin
              resp_nxt  = ST_BADPOS;
              state_nxt = S_RESP;
            end else begin
              cmd.idx_op = IDX_POS1;
              state_nxt  = S_ERS_RD;
            end
          end
          OP_FIND: begin
            cmd.idx_op = IDX_ZERO;
            state_nxt  = S_FND_RD;
          end
          OP_DUMP: begin
            if (sts.empty) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_nxt  = S_DMP_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // shift up from the top, then drop the value in
      S_INS_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd    = 1'b1;
          cmd.prev  = 1'b1;
          state_nxt = S_INS_WR;
        end else begin
          cmd.wr      = 1'b1;
          cmd.put     = 1'b1;
          cmd.cnt_inc = 1'b1;
          resp_nxt    = ST_OK;
          state_nxt   = S_RESP;
        end
      end
      S_INS_WR: begin
        cmd.wr     = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_nxt  = S_INS_RD;
      end
      // shift down from just above the erased slot
      S_ERS_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd    = 1'b1;
          state_nxt = S_ERS_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          resp_nxt    = ST_OK;
          state_nxt   = S_RESP;
        end
      end
      S_ERS_WR: begin
        cmd.wr     = 1'b1;
        cmd.prev   = 1'b1;
        cmd.idx_op = IDX_INC;
        state_nxt  = S_ERS_RD;
      end
      S_FND_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd    = 1'b1;
          state_nxt = S_FND_CMP;
        end else begin
          resp_nxt  = ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end
      S_FND_CMP: begin
        if (sts.match) begin
          resp_nxt    = ST_OK;
          use_idx_nxt = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_FND_RD;
        end
      end
      S_DMP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.use_idx    = 1'b1;
          cmd.use_data   = 1'b1;
          cmd.last       = sts.dump_last;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_op = IDX_INC;
            state_nxt  = S_DMP_RD;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_r;
          cmd.use_idx    = use_idx_r;
          cmd.last       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      resp_r    <= ST_OK;
      use_idx_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      resp_r    <= resp_nxt;
      use_idx_r <= use_idx_nxt;
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while busy");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.last) |=> (state_r == S_IDLE))
    else $error("final result without return to idle");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && cmd.wr))
    else $error("RAM read and write in one cycle");

endmodule
